// ===== hw/rtl/lruc_pkg.sv =====
package lruc_pkg;

   localparam int CAPACITY_DEFAULT = 128;
   localparam int KEY_BITS_DEFAULT = 32;
   localparam int SEQ_BITS = 48;

   localparam logic [2:0] OP_LOOKUP     = 3'd0;
   localparam logic [2:0] OP_INSERT     = 3'd1;
   localparam logic [2:0] OP_INVALIDATE = 3'd2;
   localparam logic [2:0] OP_CLEAR      = 3'd3;
   localparam logic [2:0] OP_SWEEP      = 3'd4;
   localparam logic [2:0] OP_TICK       = 3'd5;

   localparam logic [1:0] CSR_MAX_ENTRIES  = 2'd0;
   localparam logic [1:0] CSR_TTL_MS       = 2'd1;
   localparam logic [1:0] CSR_TRACK_ACCESS = 2'd2;

   localparam logic [7:0]  MAX_ENTRIES_RESET = 8'd100;
   localparam logic [31:0] TTL_MS_RESET      = 32'd300000;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] lookup_key;
      logic [63:0] payload_id;
   } lruc_req_type;

   typedef struct packed {
      logic        hit;
      logic [63:0] found_payload;
      logic [31:0] found_uses;
      logic [7:0]  removed_count;
      logic [7:0]  occupancy_out;
      logic [31:0] hits_total;
      logic [31:0] misses_total;
      logic [31:0] evictions_total;
      logic [31:0] expirations_total;
   } lruc_rsp_type;

   function automatic logic aged(input logic [31:0] now, input logic [31:0] stamp,
                                 input logic [31:0] ttl);
      logic [31:0] age;
      age = now - stamp;
      return (ttl != 32'd0) && (age >= ttl);
   endfunction

endpackage

// ===== hw/rtl/lruc_store.sv =====
module lruc_store import lruc_pkg::*; #(
   parameter int DEPTH = CAPACITY_DEFAULT,
   parameter int DATA_BITS = 8
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_BITS-1:0]     rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lru_cache_with_ttl_expiry_unit.sv =====
// Fully associative LRU cache with age expiry. Entries live in one
// single-port-read memory; every request that searches the cache walks it
// one entry per cycle. Lookup and invalidate make one scan pass, insert
// makes two (a key search pass, then a pass for the least recent entry and
// the first free slot), and an expire sweep makes one; clear, tick, a sweep
// with expiry disabled and unknown codes make none. Each scan pass is one
// read per entry, then a drain of the read pipeline. Recency is kept as a
// per-entry use sequence number; the oldest valid number marks the LRU entry.
// Valid bits sit in flip-flops and reset clears them at once, so no clearing
// pass is needed. A finished response waits in an output register while the
// next request is taken.
module lru_cache_with_ttl_expiry_unit import lruc_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  lruc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output lruc_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int IW = $clog2(CAPACITY);
   localparam int OW = $clog2(CAPACITY + 1);
   localparam int CW = (OW > 8) ? OW : 8;
   localparam int EW = KEY_BITS + 64 + 32 + 32 + SEQ_BITS;
   localparam int O_USES  = SEQ_BITS;
   localparam int O_STAMP = SEQ_BITS + 32;
   localparam int O_PAY   = SEQ_BITS + 64;
   localparam int O_KEY   = SEQ_BITS + 128;
   localparam logic [IW:0] SCAN_END = (IW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_LIMIT = CW'(CAPACITY);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_FIND    = 3'd1;
   localparam logic [2:0] S_RESOLVE = 3'd2;
   localparam logic [2:0] S_LRU     = 3'd3;
   localparam logic [2:0] S_PLACE   = 3'd4;
   localparam logic [2:0] S_SWEEP   = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [7:0] max_entries_ff, max_entries_in;
   logic [31:0] ttl_ff, ttl_in;
   logic track_ff, track_in;

   logic [2:0] op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [63:0] pay_ff, pay_in;

   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] hits_ff, hits_in, miss_ff, miss_in, evict_ff, evict_in, exp_ff, exp_in;
   logic [SEQ_BITS-1:0] seq_ff, seq_in;

   logic [IW:0] sc_ff, sc_in;
   logic dv_ff, dv_in;
   logic [IW-1:0] didx_ff, didx_in;

   logic found_ff, found_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic [EW-1:0] fent_ff, fent_in;

   logic lru_ok_ff, lru_ok_in;
   logic [IW-1:0] lru_idx_ff, lru_idx_in;
   logic [SEQ_BITS-1:0] lru_seq_ff, lru_seq_in;
   logic free_ok_ff, free_ok_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   logic res_hit_ff, res_hit_in;
   logic [63:0] res_pay_ff, res_pay_in;
   logic [31:0] res_uses_ff, res_uses_in;
   logic [OW-1:0] removed_ff, removed_in;

   logic rsp_valid_ff, rsp_valid_in;
   lruc_rsp_type rsp_ff, rsp_in;

   logic rd_en;
   logic [EW-1:0] rd_data;
   logic wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic [KEY_BITS-1:0] rd_key;
   logic [31:0] rd_stamp;
   logic [SEQ_BITS-1:0] rd_seq;
   logic scanning, scan_done, rd_live;
   logic [CW-1:0] limit, occ_wide;
   logic [31:0] uses_new;
   logic do_evict;
   logic place_ok;
   logic [IW-1:0] place_idx;

   lruc_store #(.DEPTH(CAPACITY), .DATA_BITS(EW)) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (sc_ff[IW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign rd_key   = rd_data[O_KEY +: KEY_BITS];
   assign rd_stamp = rd_data[O_STAMP +: 32];
   assign rd_seq   = rd_data[SEQ_BITS-1:0];
   assign rd_live  = dv_ff && valid_ff[didx_ff];

   assign scanning  = (state_ff == S_FIND) || (state_ff == S_LRU) || (state_ff == S_SWEEP);
   assign rd_en     = scanning && (sc_ff != SCAN_END);
   assign scan_done = (sc_ff == SCAN_END) && !dv_ff;

   assign limit    = (CW'(max_entries_ff) < CAP_LIMIT) ? CW'(max_entries_ff) : CAP_LIMIT;
   assign occ_wide = CW'(occ_ff);
   assign uses_new = fent_ff[O_USES +: 32] + {31'd0, track_ff};
   assign do_evict = (occ_wide >= limit) && lru_ok_ff;

   always_comb begin
      place_ok  = free_ok_ff || do_evict;
      place_idx = free_idx_ff;
      if (do_evict && (!free_ok_ff || (lru_idx_ff < free_idx_ff))) begin
         place_idx = lru_idx_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      max_entries_in = max_entries_ff;
      ttl_in         = ttl_ff;
      track_in       = track_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      pay_in         = pay_ff;
      valid_in       = valid_ff;
      occ_in         = occ_ff;
      now_in         = now_ff;
      hits_in        = hits_ff;
      miss_in        = miss_ff;
      evict_in       = evict_ff;
      exp_in         = exp_ff;
      seq_in         = seq_ff;
      sc_in          = sc_ff;
      dv_in          = rd_en;
      didx_in        = sc_ff[IW-1:0];
      found_in       = found_ff;
      fidx_in        = fidx_ff;
      fent_in        = fent_ff;
      lru_ok_in      = lru_ok_ff;
      lru_idx_in     = lru_idx_ff;
      lru_seq_in     = lru_seq_ff;
      free_ok_in     = free_ok_ff;
      free_idx_in    = free_idx_ff;
      res_hit_in     = res_hit_ff;
      res_pay_in     = res_pay_ff;
      res_uses_in    = res_uses_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      wr_en          = 1'b0;
      wr_addr        = fidx_ff;
      wr_data        = fent_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_MAX_ENTRIES:  max_entries_in = csr_wdata[7:0];
            CSR_TTL_MS:       ttl_in = csr_wdata;
            CSR_TRACK_ACCESS: track_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (rd_en) begin
         sc_in = sc_ff + 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_data.req_type;
               key_in      = KEY_BITS'(req_data.lookup_key);
               pay_in      = req_data.payload_id;
               sc_in       = '0;
               found_in    = 1'b0;
               lru_ok_in   = 1'b0;
               free_ok_in  = 1'b0;
               res_hit_in  = 1'b0;
               res_pay_in  = '0;
               res_uses_in = '0;
               removed_in  = '0;
               case (req_data.req_type)
                  OP_LOOKUP, OP_INSERT, OP_INVALIDATE: state_in = S_FIND;
                  OP_SWEEP: state_in = (ttl_ff != 32'd0) ? S_SWEEP : S_DONE;
                  OP_CLEAR: begin
                     valid_in = '0;
                     occ_in   = '0;
                     state_in = S_DONE;
                  end
                  OP_TICK: begin
                     now_in   = now_ff + 32'd1;
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_FIND: begin
            // keep the lowest-index match
            if (rd_live && !found_ff && (rd_key == key_ff)) begin
               found_in = 1'b1;
               fidx_in  = didx_ff;
               fent_in  = rd_data;
            end
            if (scan_done) begin
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            state_in = S_DONE;
            if (op_ff == OP_INVALIDATE) begin
               if (found_ff) begin
                  valid_in[fidx_ff] = 1'b0;
                  occ_in = occ_ff - 1'b1;
               end
            end else begin
               if (!found_ff) begin
                  miss_in = miss_ff + 32'd1;
               end else if (aged(now_ff, fent_ff[O_STAMP +: 32], ttl_ff)) begin
                  valid_in[fidx_ff] = 1'b0;
                  occ_in  = occ_ff - 1'b1;
                  exp_in  = exp_ff + 32'd1;
                  miss_in = miss_ff + 32'd1;
               end else begin
                  hits_in = hits_ff + 32'd1;
                  seq_in  = seq_ff + 1'b1;
                  wr_en   = 1'b1;
                  wr_data = fent_ff;
                  wr_data[O_USES +: 32] = uses_new;
                  wr_data[SEQ_BITS-1:0] = seq_ff;
                  if (op_ff == OP_LOOKUP) begin
                     res_hit_in  = 1'b1;
                     res_pay_in  = fent_ff[O_PAY +: 64];
                     res_uses_in = uses_new;
                  end else begin
                     // insert drops the old copy of the key
                     valid_in[fidx_ff] = 1'b0;
                     occ_in = occ_ff - 1'b1;
                  end
               end
               if (op_ff == OP_INSERT) begin
                  sc_in    = '0;
                  state_in = S_LRU;
               end
            end
         end
         S_LRU: begin
            if (rd_live && (!lru_ok_ff || (rd_seq < lru_seq_ff))) begin
               lru_ok_in  = 1'b1;
               lru_idx_in = didx_ff;
               lru_seq_in = rd_seq;
            end
            if (dv_ff && !valid_ff[didx_ff] && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = didx_ff;
            end
            if (scan_done) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            state_in = S_DONE;
            if (do_evict) begin
               valid_in[lru_idx_ff] = 1'b0;
               evict_in = evict_ff + 32'd1;
            end
            if (place_ok) begin
               valid_in[place_idx] = 1'b1;
               seq_in  = seq_ff + 1'b1;
               wr_en   = 1'b1;
               wr_addr = place_idx;
               wr_data = {key_ff, pay_ff, now_ff, 32'd0, seq_ff};
            end
            occ_in = occ_ff - {{(OW-1){1'b0}}, do_evict} + {{(OW-1){1'b0}}, place_ok};
         end
         S_SWEEP: begin
            if (rd_live && aged(now_ff, rd_stamp, ttl_ff)) begin
               valid_in[didx_ff] = 1'b0;
               occ_in     = occ_ff - 1'b1;
               exp_in     = exp_ff + 32'd1;
               removed_in = removed_ff + 1'b1;
            end
            if (scan_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_in.hit                = res_hit_ff;
               rsp_in.found_payload      = res_pay_ff;
               rsp_in.found_uses         = res_uses_ff;
               rsp_in.removed_count      = 8'(removed_ff);
               rsp_in.occupancy_out      = 8'(occ_ff);
               rsp_in.hits_total         = hits_ff;
               rsp_in.misses_total       = miss_ff;
               rsp_in.evictions_total    = evict_ff;
               rsp_in.expirations_total  = exp_ff;
               state_in                  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         max_entries_ff <= MAX_ENTRIES_RESET;
         ttl_ff         <= TTL_MS_RESET;
         track_ff       <= 1'b1;
         valid_ff       <= '0;
         occ_ff         <= '0;
         now_ff         <= '0;
         hits_ff        <= '0;
         miss_ff        <= '0;
         evict_ff       <= '0;
         exp_ff         <= '0;
         seq_ff         <= '0;
         sc_ff          <= '0;
         dv_ff          <= 1'b0;
         found_ff       <= 1'b0;
         lru_ok_ff      <= 1'b0;
         free_ok_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         max_entries_ff <= max_entries_in;
         ttl_ff         <= ttl_in;
         track_ff       <= track_in;
         valid_ff       <= valid_in;
         occ_ff         <= occ_in;
         now_ff         <= now_in;
         hits_ff        <= hits_in;
         miss_ff        <= miss_in;
         evict_ff       <= evict_in;
         exp_ff         <= exp_in;
         seq_ff         <= seq_in;
         sc_ff          <= sc_in;
         dv_ff          <= dv_in;
         found_ff       <= found_in;
         lru_ok_ff      <= lru_ok_in;
         free_ok_ff     <= free_ok_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      pay_ff      <= pay_in;
      didx_ff     <= didx_in;
      fidx_ff     <= fidx_in;
      fent_ff     <= fent_in;
      lru_idx_ff  <= lru_idx_in;
      lru_seq_ff  <= lru_seq_in;
      free_idx_ff <= free_idx_in;
      res_hit_ff  <= res_hit_in;
      res_pay_ff  <= res_pay_in;
      res_uses_ff <= res_uses_in;
      removed_ff  <= removed_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ===== dv/lru_cache_with_ttl_expiry_unit_test.sv =====
`timescale 1ns / 100ps

module lru_cache_with_ttl_expiry_unit_test;
   import lruc_pkg::*;

   localparam int SLOTS = 128;
   localparam int CYCLE_LIMIT = 1000000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   lruc_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   lruc_rsp_type rsp_data;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   // shadow copy of the cache contents
   bit          line_valid [SLOTS];
   logic [31:0] line_key [SLOTS];
   logic [63:0] line_payload [SLOTS];
   logic [31:0] line_stamp [SLOTS];
   logic [31:0] line_uses [SLOTS];
   int          line_rank [SLOTS];
   int          live_lines;
   logic [31:0] now_ms;
   logic [31:0] hit_cnt, miss_cnt, evict_cnt, expire_cnt;
   logic [7:0]  limit_reg;
   logic [31:0] ttl_reg;
   bit          track_reg;

   lruc_rsp_type pending_rsp[$];
   bit           failed;
   bit           calm;
   int           cycle_count;
   int           stall_left;

   lru_cache_with_ttl_expiry_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lru_cache_with_ttl_expiry_unit: mismatch");
         $finish;
      end
   end

   function automatic bit is_stale(int s);
      return ttl_reg != 0 && (now_ms - line_stamp[s]) >= ttl_reg;
   endfunction

   function automatic void drop_line(int s);
      line_valid[s] = 0;
      for (int i = 0; i < SLOTS; i++)
         if (line_valid[i] && line_rank[i] > line_rank[s]) line_rank[i]--;
      live_lines--;
   endfunction

   function automatic int find_line(logic [31:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (line_valid[i] && line_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int probe_line(logic [31:0] key);
      int s;
      s = find_line(key);
      if (s < 0) begin
         miss_cnt++;
         return -1;
      end
      if (is_stale(s)) begin
         drop_line(s);
         expire_cnt++;
         miss_cnt++;
         return -1;
      end
      hit_cnt++;
      if (track_reg) line_uses[s]++;
      for (int i = 0; i < SLOTS; i++)
         if (line_valid[i] && line_rank[i] < line_rank[s]) line_rank[i]++;
      line_rank[s] = 0;
      return s;
   endfunction

   function automatic void store_line(logic [31:0] key, logic [63:0] payload);
      int s, oldest, free_slot;
      int cap;
      cap = (limit_reg < SLOTS) ? limit_reg : SLOTS;
      oldest = -1;
      free_slot = -1;
      s = probe_line(key);
      if (s >= 0) drop_line(s);
      if (live_lines >= cap) begin
         for (int i = 0; i < SLOTS; i++)
            if (line_valid[i] && (oldest < 0 || line_rank[i] > line_rank[oldest])) oldest = i;
         if (oldest >= 0) begin
            drop_line(oldest);
            evict_cnt++;
         end
      end
      for (int i = 0; i < SLOTS; i++)
         if (!line_valid[i] && free_slot < 0) free_slot = i;
      if (free_slot < 0) return;
      for (int i = 0; i < SLOTS; i++)
         if (line_valid[i]) line_rank[i]++;
      line_valid[free_slot] = 1;
      line_key[free_slot] = key;
      line_payload[free_slot] = payload;
      line_stamp[free_slot] = now_ms;
      line_uses[free_slot] = 0;
      line_rank[free_slot] = 0;
      live_lines++;
   endfunction

   function automatic lruc_rsp_type predict_response(lruc_req_type r);
      lruc_rsp_type o;
      int s;
      o = '0;
      case (r.req_type)
         OP_LOOKUP: begin
            s = probe_line(r.lookup_key);
            if (s >= 0) begin
               o.hit = 1'b1;
               o.found_payload = line_payload[s];
               o.found_uses = line_uses[s];
            end
         end
         OP_INSERT: store_line(r.lookup_key, r.payload_id);
         OP_INVALIDATE: begin
            s = find_line(r.lookup_key);
            if (s >= 0) drop_line(s);
         end
         OP_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) line_valid[i] = 0;
            live_lines = 0;
         end
         OP_SWEEP: begin
            if (ttl_reg != 0)
               for (int i = 0; i < SLOTS; i++)
                  if (line_valid[i] && is_stale(i)) begin
                     drop_line(i);
                     expire_cnt++;
                     o.removed_count++;
                  end
         end
         OP_TICK: now_ms++;
         default: ;
      endcase
      o.occupancy_out = live_lines[7:0];
      o.hits_total = hit_cnt;
      o.misses_total = miss_cnt;
      o.evictions_total = evict_cnt;
      o.expirations_total = expire_cnt;
      return o;
   endfunction

   // response checker with random back-pressure
   always @(posedge clock) begin
      lruc_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected response");
               failed = 1;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.hit !== want.hit) begin
                  $error("hit: expected %0h actual %0h", want.hit, rsp_data.hit);
                  failed = 1;
               end
               if (rsp_data.found_payload !== want.found_payload) begin
                  $error("found_payload: expected %0h actual %0h",
                         want.found_payload, rsp_data.found_payload);
                  failed = 1;
               end
               if (rsp_data.found_uses !== want.found_uses) begin
                  $error("found_uses: expected %0h actual %0h",
                         want.found_uses, rsp_data.found_uses);
                  failed = 1;
               end
               if (rsp_data.removed_count !== want.removed_count) begin
                  $error("removed_count: expected %0h actual %0h",
                         want.removed_count, rsp_data.removed_count);
                  failed = 1;
               end
               if (rsp_data.occupancy_out !== want.occupancy_out) begin
                  $error("occupancy_out: expected %0h actual %0h",
                         want.occupancy_out, rsp_data.occupancy_out);
                  failed = 1;
               end
               if (rsp_data.hits_total !== want.hits_total) begin
                  $error("hits_total: expected %0h actual %0h",
                         want.hits_total, rsp_data.hits_total);
                  failed = 1;
               end
               if (rsp_data.misses_total !== want.misses_total) begin
                  $error("misses_total: expected %0h actual %0h",
                         want.misses_total, rsp_data.misses_total);
                  failed = 1;
               end
               if (rsp_data.evictions_total !== want.evictions_total) begin
                  $error("evictions_total: expected %0h actual %0h",
                         want.evictions_total, rsp_data.evictions_total);
                  failed = 1;
               end
               if (rsp_data.expirations_total !== want.expirations_total) begin
                  $error("expirations_total: expected %0h actual %0h",
                         want.expirations_total, rsp_data.expirations_total);
                  failed = 1;
               end
            end
            stall_left = calm ? 0 : $urandom_range(0, 7);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(logic [2:0] op, logic [31:0] key, logic [63:0] payload);
      lruc_req_type r;
      int gap;
      r.req_type = op;
      r.lookup_key = key;
      r.payload_id = payload;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(predict_response(r));
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MAX_ENTRIES: limit_reg = value[7:0];
         CSR_TTL_MS: ttl_reg = value;
         CSR_TRACK_ACCESS: track_reg = value[0];
         default: ;
      endcase
   endtask

   task automatic test_basic_ops();
      calm = 1;
      send_request(OP_LOOKUP, 32'h0, 64'h0);
      send_request(OP_INSERT, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_LOOKUP, 32'h0, 64'h0);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_INSERT, 32'h0, 64'h1234_5678_9ABC_DEF0);
      send_request(OP_LOOKUP, 32'h0, 64'h0);
      send_request(OP_INVALIDATE, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_INVALIDATE, 32'h5555_AAAA, 64'h0);
      send_request(OP_SWEEP, 32'h0, 64'h0);
      send_request(OP_TICK, 32'h0, 64'h0);
      send_request(3'd6, 32'h1, 64'h1);
      send_request(3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_CLEAR, 32'h0, 64'h0);
      send_request(OP_LOOKUP, 32'h0, 64'h0);
      calm = 0;
   endtask

   task automatic test_expiry_and_limits();
      write_csr(CSR_TTL_MS, 32'd2);
      write_csr(CSR_TRACK_ACCESS, 32'd0);
      send_request(OP_INSERT, 32'd10, 64'hA);
      send_request(OP_INSERT, 32'd11, 64'hB);
      send_request(OP_TICK, 32'd0, 64'h0);
      send_request(OP_LOOKUP, 32'd11, 64'h0);
      send_request(OP_TICK, 32'd0, 64'h0);
      send_request(OP_LOOKUP, 32'd10, 64'h0);
      send_request(OP_INSERT, 32'd11, 64'hC);
      send_request(OP_SWEEP, 32'd0, 64'h0);
      write_csr(CSR_TTL_MS, 32'd0);
      send_request(OP_TICK, 32'd0, 64'h0);
      send_request(OP_TICK, 32'd0, 64'h0);
      send_request(OP_SWEEP, 32'd0, 64'h0);
      // lower the limit under the occupancy: one eviction per insert
      send_request(OP_INSERT, 32'd12, 64'hD);
      send_request(OP_INSERT, 32'd13, 64'hE);
      write_csr(CSR_MAX_ENTRIES, 32'd1);
      send_request(OP_INSERT, 32'd14, 64'hF);
      send_request(OP_INSERT, 32'd15, 64'h10);
      write_csr(CSR_MAX_ENTRIES, 32'd0);
      send_request(OP_INSERT, 32'd16, 64'h11);
      send_request(OP_LOOKUP, 32'd16, 64'h0);
   endtask

   task automatic run_random_phase(int count, logic [7:0] lim, logic [31:0] ttl,
                                   bit track, int pool, int insert_weight);
      int pick;
      logic [31:0] key;
      logic [31:0] base;
      write_csr(CSR_MAX_ENTRIES, {24'd0, lim});
      write_csr(CSR_TTL_MS, ttl);
      write_csr(CSR_TRACK_ACCESS, {31'd0, track});
      base = $urandom;
      for (int n = 0; n < count; n++) begin
         calm = (n % 60) >= 45;
         pick = $urandom_range(0, 99);
         key = ($urandom_range(0, 15) == 0) ? $urandom : base + $urandom_range(0, pool - 1);
         if (pick < insert_weight)
            send_request(OP_INSERT, key, {$urandom, $urandom});
         else if (pick < 70)
            send_request(OP_LOOKUP, key, {$urandom, $urandom});
         else if (pick < 84)
            send_request(OP_TICK, $urandom, {$urandom, $urandom});
         else if (pick < 92)
            send_request(OP_INVALIDATE, key, {$urandom, $urandom});
         else if (pick < 97)
            send_request(OP_SWEEP, $urandom, {$urandom, $urandom});
         else if (pick < 98)
            send_request(OP_CLEAR, $urandom, {$urandom, $urandom});
         else
            send_request(3'($urandom_range(6, 7)), $urandom, {$urandom, $urandom});
      end
      calm = 0;
   endtask

   task automatic test_random_traffic();
      run_random_phase(100, 8'd8, 32'd20, 1'b1, 24, 40);
      run_random_phase(120, 8'd128, 32'd0, 1'b0, 200, 60);
      run_random_phase(80, 8'd0, 32'd5, 1'b1, 6, 35);
      run_random_phase(100, 8'd255, 32'hFFFF_FFFF, 1'b1, 40, 40);
      run_random_phase(100, 8'd3, 32'd1, 1'b0, 8, 40);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_MAX_ENTRIES;
      csr_wdata = '0;
      failed = 0;
      calm = 0;
      stall_left = 0;
      cycle_count = 0;
      for (int i = 0; i < SLOTS; i++) line_valid[i] = 0;
      live_lines = 0;
      now_ms = '0;
      hit_cnt = '0;
      miss_cnt = '0;
      evict_cnt = '0;
      expire_cnt = '0;
      limit_reg = MAX_ENTRIES_RESET;
      ttl_reg = TTL_MS_RESET;
      track_reg = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_expiry_and_limits();
      test_random_traffic();

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("lru_cache_with_ttl_expiry_unit: match");
      end else begin
         $display("lru_cache_with_ttl_expiry_unit: mismatch");
      end
      $finish;
   end

endmodule
